// ----- sv/cpcr_pkg.sv -----
// ----------------------------------------------------------------------------
// cpcr_pkg: shared types and constants for the circle pair collision resolver
// Field widths, register codes and reset values, and the item side-band
// records that travel through the square root and divider pipes.
// ----------------------------------------------------------------------------
`default_nettype none

package cpcr_pkg;

    // fixed field widths
    localparam int FRAC_BITS_DEF = 16;
    localparam int VAL_W         = 28;
    localparam int RAD_W         = 20;
    localparam int REG_W         = 17;
    localparam int CFG_IDX_W     = 1;

    // derived widths of the geometry path
    localparam int DIFF_W = VAL_W + 1;
    localparam int RSUM_W = RAD_W + 1;
    localparam int D2_W   = 2 * RSUM_W;
    localparam int ROOT_W = RSUM_W;
    localparam int D2F_W  = 2 * DIFF_W;
    localparam int OVP_W  = RSUM_W + REG_W;

    // configuration register codes
    localparam logic [CFG_IDX_W-1:0] CFG_RESTITUTION = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_POS_CORR    = CFG_IDX_W'(1);

    localparam logic [REG_W-1:0] RESTITUTION_RST = 17'd13107;
    localparam logic [REG_W-1:0] POS_CORR_RST    = 17'd26214;

    typedef logic signed [VAL_W-1:0] val_t;

    // the eight particle values of one item
    typedef struct packed {
        val_t p1x;
        val_t p1y;
        val_t v1x;
        val_t v1y;
        val_t p2x;
        val_t p2y;
        val_t v2x;
        val_t v2y;
    } pair_t;

    // side-band carried through the root pipe
    typedef struct packed {
        pair_t                     pair;
        logic                      contact;
        logic [RSUM_W-1:0]         rsum;
        logic                      neg_x;
        logic                      neg_y;
        logic [ROOT_W-1:0]         mag_x;
        logic [ROOT_W-1:0]         mag_y;
        logic signed [DIFF_W-1:0]  rvx;
        logic signed [DIFF_W-1:0]  rvy;
    } sq_side_t;

    // side-band carried through the divider pipe
    typedef struct packed {
        pair_t                     pair;
        logic                      contact;
        logic [OVP_W-1:0]          ov_prod;
        logic signed [DIFF_W-1:0]  rvx;
        logic signed [DIFF_W-1:0]  rvy;
    } dv_side_t;

endpackage

`default_nettype wire

// ----- sv/circle_pair_collision_resolve_unit.sv -----
// ----------------------------------------------------------------------------
// circle_pair_collision_resolve_unit: contact resolution for two circles
// Pushes an overlapping pair apart along the unit normal and exchanges an
// impulse when they approach; inactive or separate pairs pass through.
// ----------------------------------------------------------------------------
// The unit takes one particle pair per cycle while the output is not stalled
// and returns one result per pair, in order, through 31 + FRAC_BITS register
// stages. The depth is set by the 21-stage square root pipe, one stage per
// root bit, and the FRAC_BITS + 1 stage normal divider, one stage per
// quotient bit, plus nine stages of differences, products, saturation and
// the output register. The whole pipeline stalls together when the output
// item is not taken; in_ready is low only while a finished item waits at the
// output.
`default_nettype none

module circle_pair_collision_resolve_unit #(
    parameter int FRAC_BITS = cpcr_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 cfg_write,
    input  logic [cpcr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cpcr_pkg::REG_W-1:0]           cfg_data,
    // input items
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [cpcr_pkg::VAL_W-1:0]    first_pos_x,
    input  logic signed [cpcr_pkg::VAL_W-1:0]    first_pos_y,
    input  logic signed [cpcr_pkg::VAL_W-1:0]    first_vel_x,
    input  logic signed [cpcr_pkg::VAL_W-1:0]    first_vel_y,
    input  logic [cpcr_pkg::RAD_W-1:0]           first_radius,
    input  logic signed [cpcr_pkg::VAL_W-1:0]    second_pos_x,
    input  logic signed [cpcr_pkg::VAL_W-1:0]    second_pos_y,
    input  logic signed [cpcr_pkg::VAL_W-1:0]    second_vel_x,
    input  logic signed [cpcr_pkg::VAL_W-1:0]    second_vel_y,
    input  logic [cpcr_pkg::RAD_W-1:0]           second_radius,
    input  logic                                 both_active,
    // result items
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [cpcr_pkg::VAL_W-1:0]    new_first_pos_x,
    output logic signed [cpcr_pkg::VAL_W-1:0]    new_first_pos_y,
    output logic signed [cpcr_pkg::VAL_W-1:0]    new_first_vel_x,
    output logic signed [cpcr_pkg::VAL_W-1:0]    new_first_vel_y,
    output logic signed [cpcr_pkg::VAL_W-1:0]    new_second_pos_x,
    output logic signed [cpcr_pkg::VAL_W-1:0]    new_second_pos_y,
    output logic signed [cpcr_pkg::VAL_W-1:0]    new_second_vel_x,
    output logic signed [cpcr_pkg::VAL_W-1:0]    new_second_vel_y,
    output logic                                 in_contact,
    output logic                                 impulse_applied
);

    localparam int VAL_W  = cpcr_pkg::VAL_W;
    localparam int REG_W  = cpcr_pkg::REG_W;
    localparam int DIFF_W = cpcr_pkg::DIFF_W;
    localparam int RSUM_W = cpcr_pkg::RSUM_W;
    localparam int D2_W   = cpcr_pkg::D2_W;
    localparam int D2F_W  = cpcr_pkg::D2F_W;
    localparam int ROOT_W = cpcr_pkg::ROOT_W;
    localparam int OVP_W  = cpcr_pkg::OVP_W;

    localparam int N_W     = FRAC_BITS + 2;
    localparam int OV_W    = OVP_W - FRAC_BITS;
    localparam int CP_W    = OV_W + 1 + N_W;
    localparam int DV_W    = DIFF_W + N_W;
    localparam int DS_W    = DV_W + 1;
    localparam int VMAG_W  = DIFF_W + 1;
    localparam int FAC_W   = ((FRAC_BITS >= REG_W) ? FRAC_BITS : REG_W) + 1;
    localparam int IP_W    = VMAG_W + FAC_W;
    localparam int IMP_W   = IP_W - FRAC_BITS - 1;
    localparam int IX_W    = IMP_W + 1 + N_W;
    localparam int SUM_W   = ((IX_W > CP_W) ? IX_W : CP_W) + 1;
    localparam int SQS_W   = $bits(cpcr_pkg::sq_side_t);
    localparam int DVS_W   = $bits(cpcr_pkg::dv_side_t);

    localparam logic [D2F_W-1:0] EPS_Q2F =
        D2F_W'(((64'd1 << (2 * FRAC_BITS)) + 64'd5000) / 64'd10000);

    localparam logic signed [CP_W-1:0]  CP_BIAS   = CP_W'((2 ** FRAC_BITS) - 1);
    localparam logic signed [CP_W-1:0]  CP_NOBIAS = CP_W'(0);
    localparam logic signed [DS_W-1:0]  DS_BIAS   = DS_W'((2 ** FRAC_BITS) - 1);
    localparam logic signed [DS_W-1:0]  DS_NOBIAS = DS_W'(0);
    localparam logic signed [IX_W-1:0]  IX_BIAS   = IX_W'((2 ** FRAC_BITS) - 1);
    localparam logic signed [IX_W-1:0]  IX_NOBIAS = IX_W'(0);
    localparam logic [FAC_W-1:0]        FAC_ONE   = FAC_W'(2 ** FRAC_BITS);
    localparam logic signed [SUM_W-1:0] SAT_HI    = SUM_W'((2 ** (VAL_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SAT_LO    = -SAT_HI - SUM_W'(1);

    function automatic cpcr_pkg::val_t sat(input logic signed [SUM_W-1:0] v);
        cpcr_pkg::val_t r;
        if (v > SAT_HI)
        begin
            r = SAT_HI[VAL_W-1:0];
        end
        else if (v < SAT_LO)
        begin
            r = SAT_LO[VAL_W-1:0];
        end
        else
        begin
            r = v[VAL_W-1:0];
        end
        return r;
    endfunction

    logic adv;

    // configuration registers
    logic [REG_W-1:0] restitution_reg;
    logic [REG_W-1:0] pos_corr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restitution_reg <= cpcr_pkg::RESTITUTION_RST;
            pos_corr_reg    <= cpcr_pkg::POS_CORR_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                cpcr_pkg::CFG_RESTITUTION: restitution_reg <= cfg_data;
                cpcr_pkg::CFG_POS_CORR:    pos_corr_reg    <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // pipeline registers
    logic                      a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg;
    logic                      e_valid_reg, f_valid_reg, g_valid_reg, h_valid_reg;
    logic                      out_valid_reg;

    cpcr_pkg::pair_t           a_pair_reg, b_pair_reg;
    logic                      a_active_reg, b_active_reg;
    logic signed [DIFF_W-1:0]  a_dx_reg, a_dy_reg, a_rvx_reg, a_rvy_reg;
    logic [RSUM_W-1:0]         a_rsum_reg;
    logic signed [DIFF_W-1:0]  b_dx_reg, b_dy_reg, b_rvx_reg, b_rvy_reg;
    logic [RSUM_W-1:0]         b_rsum_reg;
    logic signed [D2F_W-1:0]   b_dxx_reg, b_dyy_reg;
    logic [D2_W-1:0]           b_rs2_reg;

    cpcr_pkg::sq_side_t        c_side_reg, c_side_next;
    logic [D2_W-1:0]           c_d2_reg;

    logic                      s_valid;
    logic [ROOT_W-1:0]         s_root;
    logic [SQS_W-1:0]          s_side_vec;
    cpcr_pkg::sq_side_t        s_side;

    cpcr_pkg::sq_side_t        d_side_reg;
    logic [ROOT_W-1:0]         d_root_reg;
    logic [OVP_W-1:0]          d_ov_prod_reg, d_ov_prod_next;
    cpcr_pkg::dv_side_t        dv_side_in;

    logic                      q_valid;
    logic signed [N_W-1:0]     q_nx, q_ny;
    logic [DVS_W-1:0]          q_side_vec;
    cpcr_pkg::dv_side_t        q_side;

    cpcr_pkg::pair_t           e_pair_reg;
    logic                      e_contact_reg;
    logic signed [CP_W-1:0]    e_cx_prod_reg, e_cy_prod_reg, e_cx_prod_next, e_cy_prod_next;
    logic signed [DV_W-1:0]    e_dvx_prod_reg, e_dvy_prod_reg, e_dvx_prod_next, e_dvy_prod_next;
    logic signed [N_W-1:0]     e_nx_reg, e_ny_reg;
    logic [OV_W-1:0]           ov;

    cpcr_pkg::pair_t           f_pair_reg, f_pair_next;
    logic                      f_contact_reg, f_imp_reg, f_imp_next;
    logic [VMAG_W-1:0]         f_vmag_reg, f_vmag_next;
    logic signed [N_W-1:0]     f_nx_reg, f_ny_reg;
    logic signed [CP_W-1:0]    cx, cy;
    logic signed [DS_W-1:0]    dot, van;

    cpcr_pkg::pair_t           g_pair_reg;
    logic                      g_contact_reg, g_imp_reg;
    logic [IP_W-1:0]           g_iprod_reg, g_iprod_next;
    logic signed [N_W-1:0]     g_nx_reg, g_ny_reg;
    logic [FAC_W-1:0]          fac;

    cpcr_pkg::pair_t           h_pair_reg;
    logic                      h_contact_reg, h_imp_reg;
    logic signed [IX_W-1:0]    h_ix_prod_reg, h_iy_prod_reg, h_ix_prod_next, h_iy_prod_next;
    logic [IMP_W-1:0]          imp;

    cpcr_pkg::pair_t           out_pair_reg, out_pair_next;
    logic                      out_contact_reg, out_imp_reg;
    logic signed [IX_W-1:0]    ix, iy;

    // whole pipeline moves unless a finished item is held at the output
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // stage c: squared distance, contact test, normal magnitudes
    always_comb
    begin
        logic [D2F_W-1:0] d2;
        d2 = $unsigned(b_dxx_reg) + $unsigned(b_dyy_reg);
        c_side_next.pair    = b_pair_reg;
        c_side_next.contact = b_active_reg && (d2 < D2F_W'(b_rs2_reg)) && (d2 > EPS_Q2F);
        c_side_next.rsum    = b_rsum_reg;
        c_side_next.neg_x   = b_dx_reg[DIFF_W-1];
        c_side_next.neg_y   = b_dy_reg[DIFF_W-1];
        c_side_next.mag_x   = b_dx_reg[DIFF_W-1] ? ROOT_W'(-b_dx_reg) : ROOT_W'(b_dx_reg);
        c_side_next.mag_y   = b_dy_reg[DIFF_W-1] ? ROOT_W'(-b_dy_reg) : ROOT_W'(b_dy_reg);
        c_side_next.rvx     = b_rvx_reg;
        c_side_next.rvy     = b_rvy_reg;
    end

    // root of squared distance
    cpcr_sqrt_pipe #(
        .SIDE_W (SQS_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (c_valid_reg),
        .radicand  (c_d2_reg),
        .side_in   (c_side_reg),
        .out_valid (s_valid),
        .root      (s_root),
        .side_out  (s_side_vec)
    );

    assign s_side = s_side_vec;

    // stage d: overlap times correction factor
    assign d_ov_prod_next = OVP_W'(s_side.rsum - s_root) * OVP_W'(pos_corr_reg);

    always_comb
    begin
        dv_side_in.pair    = d_side_reg.pair;
        dv_side_in.contact = d_side_reg.contact;
        dv_side_in.ov_prod = d_ov_prod_reg;
        dv_side_in.rvx     = d_side_reg.rvx;
        dv_side_in.rvy     = d_side_reg.rvy;
    end

    // unit normal
    cpcr_div_pipe #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (DVS_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (d_valid_reg),
        .divisor   (d_root_reg),
        .mag_x     (d_side_reg.mag_x),
        .mag_y     (d_side_reg.mag_y),
        .neg_x     (d_side_reg.neg_x),
        .neg_y     (d_side_reg.neg_y),
        .side_in   (dv_side_in),
        .out_valid (q_valid),
        .quo_x     (q_nx),
        .quo_y     (q_ny),
        .side_out  (q_side_vec)
    );

    assign q_side = q_side_vec;

    // stage e: correction and approach products
    assign ov              = OV_W'(q_side.ov_prod >> FRAC_BITS);
    assign e_cx_prod_next  = $signed({1'b0, ov}) * q_nx;
    assign e_cy_prod_next  = $signed({1'b0, ov}) * q_ny;
    assign e_dvx_prod_next = q_side.rvx * q_nx;
    assign e_dvy_prod_next = q_side.rvy * q_ny;

    // stage f: position correction and approach speed
    assign cx  = (e_cx_prod_reg + (e_cx_prod_reg[CP_W-1] ? CP_BIAS : CP_NOBIAS)) >>> FRAC_BITS;
    assign cy  = (e_cy_prod_reg + (e_cy_prod_reg[CP_W-1] ? CP_BIAS : CP_NOBIAS)) >>> FRAC_BITS;
    assign dot = DS_W'(e_dvx_prod_reg) + DS_W'(e_dvy_prod_reg);
    assign van = (dot + (dot[DS_W-1] ? DS_BIAS : DS_NOBIAS)) >>> FRAC_BITS;

    always_comb
    begin
        f_pair_next = e_pair_reg;
        if (e_contact_reg)
        begin
            f_pair_next.p1x = sat(SUM_W'(e_pair_reg.p1x) - SUM_W'(cx));
            f_pair_next.p1y = sat(SUM_W'(e_pair_reg.p1y) - SUM_W'(cy));
            f_pair_next.p2x = sat(SUM_W'(e_pair_reg.p2x) + SUM_W'(cx));
            f_pair_next.p2y = sat(SUM_W'(e_pair_reg.p2y) + SUM_W'(cy));
        end
        f_imp_next  = e_contact_reg && van[DS_W-1];
        f_vmag_next = VMAG_W'(-van);
    end

    // stage g: impulse magnitude product
    assign fac          = FAC_ONE + FAC_W'(restitution_reg);
    assign g_iprod_next = IP_W'(f_vmag_reg) * IP_W'(fac);

    // stage h: impulse components
    assign imp            = IMP_W'(g_iprod_reg >> (FRAC_BITS + 1));
    assign h_ix_prod_next = $signed({1'b0, imp}) * g_nx_reg;
    assign h_iy_prod_next = $signed({1'b0, imp}) * g_ny_reg;

    // output stage: velocity update
    assign ix = (h_ix_prod_reg + (h_ix_prod_reg[IX_W-1] ? IX_BIAS : IX_NOBIAS)) >>> FRAC_BITS;
    assign iy = (h_iy_prod_reg + (h_iy_prod_reg[IX_W-1] ? IX_BIAS : IX_NOBIAS)) >>> FRAC_BITS;

    always_comb
    begin
        out_pair_next = h_pair_reg;
        if (h_imp_reg)
        begin
            out_pair_next.v1x = sat(SUM_W'(h_pair_reg.v1x) - SUM_W'(ix));
            out_pair_next.v1y = sat(SUM_W'(h_pair_reg.v1y) - SUM_W'(iy));
            out_pair_next.v2x = sat(SUM_W'(h_pair_reg.v2x) + SUM_W'(ix));
            out_pair_next.v2y = sat(SUM_W'(h_pair_reg.v2y) + SUM_W'(iy));
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            e_valid_reg   <= 1'b0;
            f_valid_reg   <= 1'b0;
            g_valid_reg   <= 1'b0;
            h_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg   <= in_valid;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            d_valid_reg   <= s_valid;
            e_valid_reg   <= q_valid;
            f_valid_reg   <= e_valid_reg;
            g_valid_reg   <= f_valid_reg;
            h_valid_reg   <= g_valid_reg;
            out_valid_reg <= h_valid_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // stage a: differences and radius sum
            a_pair_reg.p1x <= first_pos_x;
            a_pair_reg.p1y <= first_pos_y;
            a_pair_reg.v1x <= first_vel_x;
            a_pair_reg.v1y <= first_vel_y;
            a_pair_reg.p2x <= second_pos_x;
            a_pair_reg.p2y <= second_pos_y;
            a_pair_reg.v2x <= second_vel_x;
            a_pair_reg.v2y <= second_vel_y;
            a_active_reg   <= both_active;
            a_dx_reg       <= DIFF_W'(second_pos_x) - DIFF_W'(first_pos_x);
            a_dy_reg       <= DIFF_W'(second_pos_y) - DIFF_W'(first_pos_y);
            a_rvx_reg      <= DIFF_W'(second_vel_x) - DIFF_W'(first_vel_x);
            a_rvy_reg      <= DIFF_W'(second_vel_y) - DIFF_W'(first_vel_y);
            a_rsum_reg     <= RSUM_W'(first_radius) + RSUM_W'(second_radius);

            // stage b: squares
            b_pair_reg   <= a_pair_reg;
            b_active_reg <= a_active_reg;
            b_dx_reg     <= a_dx_reg;
            b_dy_reg     <= a_dy_reg;
            b_rvx_reg    <= a_rvx_reg;
            b_rvy_reg    <= a_rvy_reg;
            b_rsum_reg   <= a_rsum_reg;
            b_dxx_reg    <= a_dx_reg * a_dx_reg;
            b_dyy_reg    <= a_dy_reg * a_dy_reg;
            b_rs2_reg    <= D2_W'(a_rsum_reg) * D2_W'(a_rsum_reg);

            // stage c
            c_side_reg <= c_side_next;
            c_d2_reg   <= D2_W'($unsigned(b_dxx_reg) + $unsigned(b_dyy_reg));

            // stage d
            d_side_reg    <= s_side;
            d_root_reg    <= s_root;
            d_ov_prod_reg <= d_ov_prod_next;

            // stage e
            e_pair_reg      <= q_side.pair;
            e_contact_reg   <= q_side.contact;
            e_cx_prod_reg   <= e_cx_prod_next;
            e_cy_prod_reg   <= e_cy_prod_next;
            e_dvx_prod_reg  <= e_dvx_prod_next;
            e_dvy_prod_reg  <= e_dvy_prod_next;
            e_nx_reg        <= q_nx;
            e_ny_reg        <= q_ny;

            // stage f
            f_pair_reg    <= f_pair_next;
            f_contact_reg <= e_contact_reg;
            f_imp_reg     <= f_imp_next;
            f_vmag_reg    <= f_vmag_next;
            f_nx_reg      <= e_nx_reg;
            f_ny_reg      <= e_ny_reg;

            // stage g
            g_pair_reg    <= f_pair_reg;
            g_contact_reg <= f_contact_reg;
            g_imp_reg     <= f_imp_reg;
            g_iprod_reg   <= g_iprod_next;
            g_nx_reg      <= f_nx_reg;
            g_ny_reg      <= f_ny_reg;

            // stage h
            h_pair_reg    <= g_pair_reg;
            h_contact_reg <= g_contact_reg;
            h_imp_reg     <= g_imp_reg;
            h_ix_prod_reg <= h_ix_prod_next;
            h_iy_prod_reg <= h_iy_prod_next;

            // output register
            out_pair_reg    <= out_pair_next;
            out_contact_reg <= h_contact_reg;
            out_imp_reg     <= h_imp_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign new_first_pos_x  = out_pair_reg.p1x;
    assign new_first_pos_y  = out_pair_reg.p1y;
    assign new_first_vel_x  = out_pair_reg.v1x;
    assign new_first_vel_y  = out_pair_reg.v1y;
    assign new_second_pos_x = out_pair_reg.p2x;
    assign new_second_pos_y = out_pair_reg.p2y;
    assign new_second_vel_x = out_pair_reg.v2x;
    assign new_second_vel_y = out_pair_reg.v2y;
    assign in_contact       = out_contact_reg;
    assign impulse_applied  = out_imp_reg;

endmodule

`default_nettype wire

// ----- sv/cpcr_sqrt_pipe.sv -----
// ----------------------------------------------------------------------------
// cpcr_sqrt_pipe: pipelined integer square root
// One root bit is decided per stage by a compare and subtract on the
// remainder; a side-band word travels alongside each item.
// ----------------------------------------------------------------------------
`default_nettype none

module cpcr_sqrt_pipe #(
    parameter int SIDE_W = 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic [cpcr_pkg::D2_W-1:0]     radicand,
    input  logic [SIDE_W-1:0]             side_in,
    output logic                          out_valid,
    output logic [cpcr_pkg::ROOT_W-1:0]   root,
    output logic [SIDE_W-1:0]             side_out
);

    localparam int NS  = cpcr_pkg::ROOT_W;
    localparam int RDW = cpcr_pkg::D2_W;
    localparam int TW  = RDW + 2;

    logic              valid_reg [NS];
    logic [RDW-1:0]    rem_reg   [NS];
    logic [RDW-1:0]    rem_next  [NS];
    logic [NS-1:0]     root_reg  [NS];
    logic [NS-1:0]     root_next [NS];
    logic [SIDE_W-1:0] side_reg  [NS];
    logic [RDW-1:0]    rem_src   [NS];
    logic [NS-1:0]     root_src  [NS];

    // stage inputs
    always_comb
    begin
        rem_src[0]  = radicand;
        root_src[0] = '0;
        for (int i = 1; i < NS; i++)
        begin
            rem_src[i]  = rem_reg[i-1];
            root_src[i] = root_reg[i-1];
        end
    end

    // one root bit per stage, most significant first
    always_comb
    begin
        logic [TW-1:0] trial;
        for (int i = 0; i < NS; i++)
        begin
            trial = (TW'(root_src[i]) << (NS - i)) + (TW'(1) << (2 * (NS - 1 - i)));
            if ({2'b00, rem_src[i]} >= trial)
            begin
                rem_next[i]  = rem_src[i] - RDW'(trial);
                root_next[i] = root_src[i] | (NS'(1) << (NS - 1 - i));
            end
            else
            begin
                rem_next[i]  = rem_src[i];
                root_next[i] = root_src[i];
            end
        end
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < NS; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    // data chain
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_in;
            for (int i = 1; i < NS; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
            for (int i = 0; i < NS; i++)
            begin
                rem_reg[i]  <= rem_next[i];
                root_reg[i] <= root_next[i];
            end
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign root      = root_reg[NS-1];
    assign side_out  = side_reg[NS-1];

endmodule

`default_nettype wire

// ----- sv/cpcr_div_pipe.sv -----
// ----------------------------------------------------------------------------
// cpcr_div_pipe: two-lane pipelined restoring divider for the unit normal
// Each lane divides a magnitude scaled by 2^FRAC_BITS by the shared distance,
// one quotient bit per stage, and applies the sign at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module cpcr_div_pipe #(
    parameter int FRAC_BITS = cpcr_pkg::FRAC_BITS_DEF,
    parameter int SIDE_W    = 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic [cpcr_pkg::ROOT_W-1:0]   divisor,
    input  logic [cpcr_pkg::ROOT_W-1:0]   mag_x,
    input  logic [cpcr_pkg::ROOT_W-1:0]   mag_y,
    input  logic                          neg_x,
    input  logic                          neg_y,
    input  logic [SIDE_W-1:0]             side_in,
    output logic                          out_valid,
    output logic signed [FRAC_BITS+1:0]   quo_x,
    output logic signed [FRAC_BITS+1:0]   quo_y,
    output logic [SIDE_W-1:0]             side_out
);

    localparam int QW = FRAC_BITS + 1;
    localparam int DW = cpcr_pkg::ROOT_W;
    localparam int RW = DW + FRAC_BITS + 1;

    logic              valid_reg [QW];
    logic [DW-1:0]     div_reg   [QW];
    logic [SIDE_W-1:0] side_reg  [QW];
    logic [RW-1:0]     rem_reg   [QW][2];
    logic [RW-1:0]     rem_next  [QW][2];
    logic [QW-1:0]     q_reg     [QW][2];
    logic [QW-1:0]     q_next    [QW][2];
    logic              neg_reg   [QW][2];
    logic [DW-1:0]     div_src   [QW];
    logic [RW-1:0]     rem_src   [QW][2];
    logic [QW-1:0]     q_src     [QW][2];

    // stage inputs
    always_comb
    begin
        div_src[0]    = divisor;
        rem_src[0][0] = RW'(mag_x) << FRAC_BITS;
        rem_src[0][1] = RW'(mag_y) << FRAC_BITS;
        q_src[0][0]   = '0;
        q_src[0][1]   = '0;
        for (int i = 1; i < QW; i++)
        begin
            div_src[i] = div_reg[i-1];
            for (int j = 0; j < 2; j++)
            begin
                rem_src[i][j] = rem_reg[i-1][j];
                q_src[i][j]   = q_reg[i-1][j];
            end
        end
    end

    // one quotient bit per stage and lane
    always_comb
    begin
        logic [RW-1:0] dsh;
        for (int i = 0; i < QW; i++)
        begin
            dsh = RW'(div_src[i]) << (QW - 1 - i);
            for (int j = 0; j < 2; j++)
            begin
                if (rem_src[i][j] >= dsh)
                begin
                    rem_next[i][j] = rem_src[i][j] - dsh;
                    q_next[i][j]   = q_src[i][j] | (QW'(1) << (QW - 1 - i));
                end
                else
                begin
                    rem_next[i][j] = rem_src[i][j];
                    q_next[i][j]   = q_src[i][j];
                end
            end
        end
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QW; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < QW; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    // data chain
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0]   <= side_in;
            div_reg[0]    <= divisor;
            neg_reg[0][0] <= neg_x;
            neg_reg[0][1] <= neg_y;
            for (int i = 1; i < QW; i++)
            begin
                side_reg[i]   <= side_reg[i-1];
                div_reg[i]    <= div_reg[i-1];
                neg_reg[i][0] <= neg_reg[i-1][0];
                neg_reg[i][1] <= neg_reg[i-1][1];
            end
            for (int i = 0; i < QW; i++)
            begin
                for (int j = 0; j < 2; j++)
                begin
                    rem_reg[i][j] <= rem_next[i][j];
                    q_reg[i][j]   <= q_next[i][j];
                end
            end
        end
    end

    // signed quotients, truncated toward zero
    assign quo_x = neg_reg[QW-1][0] ? -$signed({1'b0, q_reg[QW-1][0]})
                                    :  $signed({1'b0, q_reg[QW-1][0]});
    assign quo_y = neg_reg[QW-1][1] ? -$signed({1'b0, q_reg[QW-1][1]})
                                    :  $signed({1'b0, q_reg[QW-1][1]});

    assign out_valid = valid_reg[QW-1];
    assign side_out  = side_reg[QW-1];

endmodule

`default_nettype wire

// ----- sv/cpcr_checker.sv -----
// ----------------------------------------------------------------------------
// cpcr_checker: port-level checks for the circle pair collision resolver
// Watches reset, flow control and result flags on the top level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module cpcr_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic signed [cpcr_pkg::VAL_W-1:0]  new_first_pos_x,
    input logic signed [cpcr_pkg::VAL_W-1:0]  new_second_vel_y,
    input logic                               in_contact,
    input logic                               impulse_applied
);

    // no result item while in reset
    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result item shown during reset");

    // input side only stalls while the output item is held
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not follow output stall");

    // an impulse is only exchanged on a contact
    a_imp_contact: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !in_contact |-> !impulse_applied)
        else $error("impulse flagged without contact");

    // a stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(new_first_pos_x)
            && $stable(new_second_vel_y) && $stable(in_contact)
            && $stable(impulse_applied))
        else $error("stalled result item changed");

endmodule

bind circle_pair_collision_resolve_unit cpcr_checker u_cpcr_checker (.*);

`default_nettype wire
